>>> hdl/rrpe_pkg.sv
package rrpe_pkg;

  localparam int Pointers      = 4;
  localparam int SineTableBits = 10;
  localparam int PtrW          = (Pointers > 1) ? $clog2(Pointers) : 1;
  localparam int TableSize     = 1 << SineTableBits;
  localparam int QuarterSize   = TableSize / 4;
  localparam int QuarterW      = SineTableBits - 1;
  localparam logic [15:0] QuarterTurn = 16'h4000;
  localparam logic signed [15:0] SineOne = 16'sd16384;
  localparam longint unsigned PiQ30 = 64'd3373259426;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MAX_X = 3'd1,
    REG_BOX_MIN_Y = 3'd2,
    REG_BOX_MAX_Y = 3'd3,
    REG_PIVOT_X   = 3'd4,
    REG_PIVOT_Y   = 3'd5,
    REG_ANGLE     = 3'd6,
    REG_CONTROL   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] box_min_x;
    logic signed [15:0] box_max_x;
    logic signed [15:0] box_min_y;
    logic signed [15:0] box_max_y;
    logic signed [15:0] pivot_x;
    logic signed [15:0] pivot_y;
  } region_t;

  typedef logic [QuarterSize:0][14:0] sine_tab_t;

  // Quarter-wave sine in Q1.14, built at elaboration from a truncated Taylor series in Q2.30.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t        tab;
    longint unsigned  x;
    longint unsigned  sum;
    longint unsigned  term;
    longint unsigned  r;
    for (int k = 0; k <= QuarterSize; k++) begin
      x    = (PiQ30 * longint'(k)) >> (SineTableBits - 1);
      sum  = x;
      term = x;
      for (int n = 1; n <= 8; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        case (n)
          1:       term = term / 64'd6;
          2:       term = term / 64'd20;
          3:       term = term / 64'd42;
          4:       term = term / 64'd72;
          5:       term = term / 64'd110;
          6:       term = term / 64'd156;
          7:       term = term / 64'd210;
          default: term = term / 64'd272;
        endcase
        if ((n % 2) == 1) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      r = (sum + 64'd32768) >> 16;
      if (r > 64'd16384) begin
        r = 64'd16384;
      end
      tab[k] = r[14:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SineQuarter = build_sine_tab();

  function automatic logic signed [15:0] sine_lookup(input logic [15:0] ang);
    logic [SineTableBits-1:0] i;
    logic [1:0]               quad;
    logic [QuarterW-1:0]      k;
    logic [QuarterW-1:0]      pos;
    logic [14:0]              v;
    i    = ang[15 -: SineTableBits];
    quad = i[SineTableBits-1 -: 2];
    k    = {1'b0, i[SineTableBits-3:0]};
    pos  = (quad[0]) ? QuarterW'(QuarterSize) - k : k;
    v    = SineQuarter[pos];
    return quad[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

endpackage

>>> hdl/rotated_region_pointer_events.sv
// Channel   Direction  Handshake               Content
// s_axis    in         tvalid/tready           one pointer sample
// m_axis    out        tvalid/tready           one event item per sample
// cfg       in         we (no wait)            register index and value
//
// One item is taken per cycle while the result register is empty or taken.
// The stages are the input register with the stored-position read, the product
// register of the rotation multipliers, and the result register.
// All stages advance together whenever the result register is empty or taken.
// Reset clears valids, configuration and the stored positions; no clearing pass.
module rotated_region_pointer_events import rrpe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [1:0] pointer_index, [17:2] pos_x, [33:18] pos_y, [34] flag_zero,
  // [35] flag_one, [36] flag_two, [37] input_locked, [39:38] zero
  input  logic [39:0]         s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [1:0] out_index, [2] processed, [3] enter_event, [4] inside_event,
  // [5] leave_event, [6] flag_zero_event, [7] flag_two_event, [8] flag_one_event,
  // [15:9] zero
  output logic [15:0]         m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  region_t            region_q;
  logic [15:0]        angle_q;
  logic [1:0]         control_q;
  logic signed [15:0] sin_w, cos_w;

  logic signed [15:0] last_x_q [Pointers];
  logic signed [15:0] last_y_q [Pointers];

  logic               en;
  logic               accept;
  logic [1:0]         in_idx;
  logic signed [15:0] in_x, in_y;
  logic               in_f0, in_f1, in_f2, in_locked;
  logic               in_go;
  logic [PtrW-1:0]    in_ptr;

  logic               s1_valid_q, s2_valid_q, out_valid_q;
  logic [1:0]         s1_idx_q, s2_idx_q;
  logic               s1_go_q, s2_go_q;
  logic [2:0]         s1_flags_q, s2_flags_q;
  logic signed [15:0] s1_x_q, s1_y_q, s1_px_q, s1_py_q;
  logic               now_in, was_in;
  logic [8:0]         out_d, out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q  <= '0;
      angle_q   <= '0;
      control_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_BOX_MIN_X: region_q.box_min_x <= cfg_data_i;
        REG_BOX_MAX_X: region_q.box_max_x <= cfg_data_i;
        REG_BOX_MIN_Y: region_q.box_min_y <= cfg_data_i;
        REG_BOX_MAX_Y: region_q.box_max_y <= cfg_data_i;
        REG_PIVOT_X:   region_q.pivot_x   <= cfg_data_i;
        REG_PIVOT_Y:   region_q.pivot_y   <= cfg_data_i;
        REG_ANGLE:     angle_q            <= cfg_data_i;
        REG_CONTROL:   control_q          <= cfg_data_i[1:0];
        default:       ;
      endcase
    end
  end

  rrpe_sine u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .angle_i (angle_q),
    .sin_o   (sin_w),
    .cos_o   (cos_w)
  );

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  assign in_idx    = s_axis_tdata[1:0];
  assign in_x      = s_axis_tdata[17:2];
  assign in_y      = s_axis_tdata[33:18];
  assign in_f0     = s_axis_tdata[34];
  assign in_f1     = s_axis_tdata[35];
  assign in_f2     = s_axis_tdata[36];
  assign in_locked = s_axis_tdata[37];
  assign in_ptr    = PtrW'(in_idx);
  assign in_go     = !control_q[0] && (!in_locked || control_q[1]) &&
                     (32'(in_idx) < 32'(Pointers));

  // The stored position is read and replaced at the accepting edge, so the next item
  // for the same pointer already sees this one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < Pointers; p++) begin
        last_x_q[p] <= '0;
        last_y_q[p] <= '0;
      end
    end else if (accept && in_go) begin
      last_x_q[in_ptr] <= in_x;
      last_y_q[in_ptr] <= in_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= s_axis_tvalid;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_idx_q   <= in_idx;
      s1_go_q    <= in_go;
      s1_flags_q <= {in_f2, in_f1, in_f0};
      s1_x_q     <= in_x;
      s1_y_q     <= in_y;
      s1_px_q    <= in_go ? last_x_q[in_ptr] : 16'sd0;
      s1_py_q    <= in_go ? last_y_q[in_ptr] : 16'sd0;
      s2_idx_q   <= s1_idx_q;
      s2_go_q    <= s1_go_q;
      s2_flags_q <= s1_flags_q;
      out_q      <= out_d;
    end
  end

  rrpe_hit u_hit_now (
    .clk_i    (clk_i),
    .en_i     (en),
    .x_i      (s1_x_q),
    .y_i      (s1_y_q),
    .region_i (region_q),
    .sin_i    (sin_w),
    .cos_i    (cos_w),
    .inside_o (now_in)
  );

  rrpe_hit u_hit_prev (
    .clk_i    (clk_i),
    .en_i     (en),
    .x_i      (s1_px_q),
    .y_i      (s1_py_q),
    .region_i (region_q),
    .sin_i    (sin_w),
    .cos_i    (cos_w),
    .inside_o (was_in)
  );

  always_comb begin
    out_d      = '0;
    out_d[1:0] = s2_idx_q;
    if (s2_go_q) begin
      out_d[2] = 1'b1;
      out_d[3] = now_in && !was_in;
      out_d[4] = now_in;
      out_d[5] = !now_in && was_in;
      out_d[6] = now_in && s2_flags_q[0];
      out_d[7] = now_in && s2_flags_q[2];
      out_d[8] = s2_flags_q[1];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q};

  a_unprocessed_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q[2]) |-> (out_q[8:3] == 6'd0))
    else $error("event bits set on an unprocessed item");

  a_enter_leave_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q[3] && out_q[5]))
    else $error("enter and leave reported together");

  a_flag_needs_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q[6] || out_q[7] || out_q[3])) |-> out_q[4])
    else $error("inside-qualified event without inside");

  a_pipe_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && en) |=> out_valid_q)
    else $error("item lost between product and result stage");

endmodule

>>> hdl/rrpe_sine.sv
module rrpe_sine import rrpe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        angle_i,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);

  logic signed [15:0] sin_d, sin_q;
  logic signed [15:0] cos_d, cos_q;

  // A zero angle forces an exact identity so the rotated test equals the plain box test.
  always_comb begin
    if (angle_i == 16'd0) begin
      sin_d = 16'sd0;
      cos_d = SineOne;
    end else begin
      sin_d = sine_lookup(angle_i);
      cos_d = sine_lookup(angle_i + QuarterTurn);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sin_q <= 16'sd0;
      cos_q <= SineOne;
    end else begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

>>> hdl/rrpe_hit.sv
module rrpe_hit import rrpe_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  input  region_t            region_i,
  input  logic signed [15:0] sin_i,
  input  logic signed [15:0] cos_i,
  output logic               inside_o
);

  logic signed [16:0] dx, dy;
  logic signed [32:0] pxc_d, pxc_q, pys_d, pys_q, pxs_d, pxs_q, pyc_d, pyc_q;
  logic signed [35:0] rx, ry;

  assign dx = 17'(x_i) - 17'(region_i.pivot_x);
  assign dy = 17'(y_i) - 17'(region_i.pivot_y);

  assign pxc_d = 33'(dx * cos_i);
  assign pys_d = 33'(dy * sin_i);
  assign pxs_d = 33'(dx * sin_i);
  assign pyc_d = 33'(dy * cos_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxc_q <= pxc_d;
      pys_q <= pys_d;
      pxs_q <= pxs_d;
      pyc_q <= pyc_d;
    end
  end

  assign rx = 36'(pxc_q) + 36'(pys_q) + (36'(region_i.pivot_x) <<< 14);
  assign ry = 36'(pyc_q) - 36'(pxs_q) + (36'(region_i.pivot_y) <<< 14);

  assign inside_o = (rx >= (36'(region_i.box_min_x) <<< 14)) &&
                    (rx <= (36'(region_i.box_max_x) <<< 14)) &&
                    (ry >= (36'(region_i.box_min_y) <<< 14)) &&
                    (ry <= (36'(region_i.box_max_y) <<< 14));

endmodule
